// ===== hw/rtl/ept_pkg.sv =====
// ----------------------------------------------------------------------------
// ept_pkg
// Shared widths, constants, reset values and types of the encoder period
// tachometer.
// ----------------------------------------------------------------------------
package ept_pkg;

    // default parameter values
    localparam int unsigned AVG_DEPTH_DEF   = 8;
    localparam int unsigned PERIOD_BITS_DEF = 32;

    // field widths
    localparam int unsigned PPR_BITS      = 10;
    localparam int unsigned RPM_BITS      = 16;
    localparam int unsigned FREQ_BITS     = 20;
    localparam int unsigned CFG_IDX_BITS  = 2;
    localparam int unsigned CFG_DATA_BITS = 16;

    // divider dividend width (enough for ticks per minute) and step counter
    localparam int unsigned DVD_BITS  = 26;
    localparam int unsigned STEP_BITS = 5;

    // tick rate constants
    localparam logic [DVD_BITS-1:0] TICKS_PER_SECOND = 26'd1000000;
    localparam logic [DVD_BITS-1:0] TICKS_PER_MINUTE = 26'd60000000;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_PPR     = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_RPM = 2'd1;

    // register reset values
    localparam logic [PPR_BITS-1:0] PPR_RESET     = 10'd45;
    localparam logic [RPM_BITS-1:0] MAX_RPM_RESET = 16'd20000;

    // request to the shared divider
    typedef struct packed {
        logic                 start;
        logic [STEP_BITS-1:0] steps;
    } t_div_req;

    // width of the running sum of the speed ring
    function automatic int unsigned sum_bits(input int unsigned depth);
        sum_bits = RPM_BITS + $clog2(depth);
    endfunction

endpackage

// ===== hw/rtl/ept_front.sv =====
// ----------------------------------------------------------------------------
// ept_front
// Falling edge detection on the sampled pin and the saturating period
// counter; flags each edge that closes a nonzero period.
// ----------------------------------------------------------------------------
module ept_front #(
    parameter int unsigned PERIOD_BITS = ept_pkg::PERIOD_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic                   i_level,
    output logic                   o_close,
    output logic [PERIOD_BITS-1:0] o_period
);

    localparam logic [PERIOD_BITS-1:0] PERIOD_MAX = '1;

    logic                   r_last;
    logic                   r_armed;
    logic [PERIOD_BITS-1:0] r_count;
    logic [PERIOD_BITS-1:0] n_count;
    logic                   w_fall;

    // count ticks once armed, holding at the top
    assign n_count = (r_armed && (r_count != PERIOD_MAX)) ? r_count + 1'b1 : r_count;
    assign w_fall  = r_last & ~i_level;

    assign o_close  = i_accept & w_fall & r_armed & (n_count != '0);
    assign o_period = n_count;

    // edge and counter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= 1'b0;
            r_armed <= 1'b0;
            r_count <= '0;
        end else if (i_accept) begin
            r_last <= i_level;
            if (w_fall) begin
                r_armed <= 1'b1;
                r_count <= '0;
            end else begin
                r_count <= n_count;
            end
        end
    end

endmodule

// ===== hw/rtl/ept_div.sv =====
// ----------------------------------------------------------------------------
// ept_div
// Shared restoring divider, one quotient bit per cycle. The dividend comes
// left aligned and the step count says how many of its bits are used.
// ----------------------------------------------------------------------------
module ept_div #(
    parameter int unsigned DIV_BITS = ept_pkg::PERIOD_BITS_DEF + ept_pkg::PPR_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ept_pkg::t_div_req            i_req,
    input  logic [ept_pkg::DVD_BITS-1:0] i_dividend,
    input  logic [DIV_BITS-1:0]          i_divisor,
    output logic                         o_done,
    output logic [ept_pkg::DVD_BITS-1:0] o_quotient
);

    localparam int unsigned DVD_BITS = ept_pkg::DVD_BITS;
    localparam int unsigned CMP_BITS = DIV_BITS + 2;

    logic                              r_busy;
    logic                              r_done;
    logic [ept_pkg::STEP_BITS-1:0]     r_cnt;
    logic [DVD_BITS-1:0]               r_rem;
    logic [DVD_BITS-1:0]               r_quo;
    logic [DIV_BITS-1:0]               r_div;
    logic [DVD_BITS:0]                 w_rem_sh;
    logic [CMP_BITS-1:0]               w_cmp;
    logic [CMP_BITS-1:0]               w_diff;
    logic                              w_ge;
    logic [DVD_BITS-1:0]               n_rem;
    logic [DVD_BITS-1:0]               n_quo;

    // one trial subtraction
    assign w_rem_sh = {r_rem, r_quo[DVD_BITS-1]};
    assign w_cmp    = CMP_BITS'(w_rem_sh);
    assign w_diff   = w_cmp - CMP_BITS'(r_div);
    assign w_ge     = (w_cmp >= CMP_BITS'(r_div));
    assign n_rem    = w_ge ? w_diff[DVD_BITS-1:0] : w_rem_sh[DVD_BITS-1:0];
    assign n_quo    = {r_quo[DVD_BITS-2:0], w_ge};

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == ept_pkg::STEP_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

endmodule

// ===== hw/rtl/ept_ring.sv =====
// ----------------------------------------------------------------------------
// ept_ring
// Speed ring for the moving average: a small memory with a valid bit per
// entry, the write slot and the running total of the stored speeds.
// ----------------------------------------------------------------------------
module ept_ring #(
    parameter int unsigned AVG_DEPTH = ept_pkg::AVG_DEPTH_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_push,
    input  logic [ept_pkg::RPM_BITS-1:0]            i_speed,
    output logic [ept_pkg::sum_bits(AVG_DEPTH)-1:0] o_total
);

    localparam int unsigned SLOT_BITS = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int unsigned SUM_BITS  = ept_pkg::sum_bits(AVG_DEPTH);

    logic [ept_pkg::RPM_BITS-1:0] r_mem [AVG_DEPTH];
    logic [ept_pkg::RPM_BITS-1:0] r_rd_data;
    logic                         r_rd_live;
    logic [AVG_DEPTH-1:0]         r_live;
    logic [SLOT_BITS-1:0]         r_slot;
    logic [SUM_BITS-1:0]          r_total;
    logic [ept_pkg::RPM_BITS-1:0] w_old;
    logic [SLOT_BITS-1:0]         n_slot;
    logic [SUM_BITS-1:0]          n_total;

    // an entry never written reads as zero
    assign w_old   = r_rd_live ? r_rd_data : '0;
    assign n_total = r_total - SUM_BITS'(w_old) + SUM_BITS'(i_speed);
    assign n_slot  = (r_slot == SLOT_BITS'(AVG_DEPTH - 1)) ? '0 : r_slot + 1'b1;

    assign o_total = r_total;

    // memory write and registered read at the current slot
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_slot] <= i_speed;
        end
        r_rd_data <= r_mem[r_slot];
    end

    // valid bits, slot and total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live    <= '0;
            r_rd_live <= 1'b0;
            r_slot    <= '0;
            r_total   <= '0;
        end else begin
            r_rd_live <= r_live[r_slot];
            if (i_push) begin
                r_live[r_slot] <= 1'b1;
                r_slot         <= n_slot;
                r_total        <= n_total;
            end
        end
    end

endmodule

// ===== hw/rtl/encoder_period_tachometer_core.sv =====
// ----------------------------------------------------------------------------
// encoder_period_tachometer_core
// Period measuring tachometer: times falling edges of the encoder pin in
// microsecond ticks and gives frequency, clamped speed and a moving average
// of the speed over AVG_DEPTH periods (eight by default) per closed period.
//
//   channel  direction  handshake           word
//   input    in         i_valid / o_stall   i_pin_level
//   output   out        o_valid / i_stall   o_frequency_hz, o_raw_rpm,
//                                           o_average_rpm
//   config   in         i_cfg_we            i_cfg_idx, i_cfg_data
//
// A tick that closes no period leaves the block idle. A closing edge is taken
// and then holds o_stall high through the multiply, the frequency divide (20
// quotient bits), the speed divide (26 quotient bits), the ring update, the
// average (reciprocal multiply) and the output load. The load waits, with
// o_stall still high, while the output register holds a word not yet taken;
// otherwise a finished word waits there while the next ticks are taken. Reset
// clears the speed ring through per-entry valid bits.
// ----------------------------------------------------------------------------
module encoder_period_tachometer_core #(
    parameter int unsigned AVG_DEPTH   = ept_pkg::AVG_DEPTH_DEF,
    parameter int unsigned PERIOD_BITS = ept_pkg::PERIOD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_pin_level,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [ept_pkg::FREQ_BITS-1:0]     o_frequency_hz,
    output logic [ept_pkg::RPM_BITS-1:0]      o_raw_rpm,
    output logic [ept_pkg::RPM_BITS-1:0]      o_average_rpm,
    input  logic                              i_cfg_we,
    input  logic [ept_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [ept_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int unsigned DVD_BITS  = ept_pkg::DVD_BITS;
    localparam int unsigned DIV_BITS  = PERIOD_BITS + ept_pkg::PPR_BITS;
    localparam int unsigned SUM_BITS  = ept_pkg::sum_bits(AVG_DEPTH);
    localparam int unsigned FREQ_BITS = ept_pkg::FREQ_BITS;
    localparam int unsigned RPM_BITS  = ept_pkg::RPM_BITS;

    // reciprocal of the ring depth, exact for every total the ring can hold
    localparam int unsigned RCP_SHIFT = SUM_BITS + $clog2(AVG_DEPTH);
    localparam int unsigned RCP_BITS  = SUM_BITS + 1;
    localparam int unsigned PROD_BITS = SUM_BITS + RCP_BITS;
    localparam logic [RCP_BITS-1:0] RCP_MUL =
        RCP_BITS'(((64'd1 << RCP_SHIFT) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MUL   = 7'b0000010,
        ST_DIV_F = 7'b0000100,
        ST_DIV_R = 7'b0001000,
        ST_PUSH  = 7'b0010000,
        ST_AVG   = 7'b0100000,
        ST_DONE  = 7'b1000000
    } t_state;

    t_state                      r_state;
    t_state                      n_state;
    logic                        w_accept;
    logic                        w_close;
    logic [PERIOD_BITS-1:0]      w_period;
    logic [PERIOD_BITS-1:0]      r_period;
    logic [DIV_BITS-1:0]         r_denom;
    logic [FREQ_BITS-1:0]        r_freq;
    logic [RPM_BITS-1:0]         r_speed;
    logic [RPM_BITS-1:0]         r_avg;
    logic [ept_pkg::PPR_BITS-1:0] r_ppr;
    logic [RPM_BITS-1:0]         r_max_rpm;
    logic                        r_out_valid;
    logic [FREQ_BITS-1:0]        r_out_freq;
    logic [RPM_BITS-1:0]         r_out_raw;
    logic [RPM_BITS-1:0]         r_out_avg;
    ept_pkg::t_div_req           w_div_req;
    logic [DVD_BITS-1:0]         w_dividend;
    logic [DIV_BITS-1:0]         w_divisor;
    logic                        w_div_done;
    logic [DVD_BITS-1:0]         w_quo;
    logic                        w_push;
    logic                        w_load_out;
    logic                        w_out_free;
    logic [SUM_BITS-1:0]         w_total;
    logic [PROD_BITS-1:0]        w_avg_prod;
    logic [RPM_BITS-1:0]         w_clamped;

    assign w_accept   = i_valid & ~o_stall;
    assign o_stall    = (r_state != ST_IDLE);
    assign w_out_free = ~r_out_valid | ~i_stall;

    // clamp of the raw speed quotient
    assign w_clamped = (w_quo > DVD_BITS'(r_max_rpm)) ? r_max_rpm : w_quo[RPM_BITS-1:0];

    // ring total times the reciprocal of the depth
    assign w_avg_prod = PROD_BITS'(w_total) * PROD_BITS'(RCP_MUL);

    // edge detection and period counter
    ept_front #(
        .PERIOD_BITS (PERIOD_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_level  (i_pin_level),
        .o_close  (w_close),
        .o_period (w_period)
    );

    // shared divider
    ept_div #(
        .DIV_BITS (DIV_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_div_req),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // speed ring and running total
    ept_ring #(
        .AVG_DEPTH (AVG_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_speed (r_speed),
        .o_total (w_total)
    );

    // sequencer
    always_comb begin
        n_state         = r_state;
        w_div_req.start = 1'b0;
        w_div_req.steps = '0;
        w_dividend      = '0;
        w_divisor       = '0;
        w_push          = 1'b0;
        w_load_out      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_close) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                w_div_req.start = 1'b1;
                w_div_req.steps = ept_pkg::STEP_BITS'(FREQ_BITS);
                w_dividend      = ept_pkg::TICKS_PER_SECOND << (DVD_BITS - FREQ_BITS);
                w_divisor       = DIV_BITS'(r_period);
                n_state         = ST_DIV_F;
            end
            ST_DIV_F: begin
                if (w_div_done) begin
                    w_div_req.start = 1'b1;
                    w_div_req.steps = ept_pkg::STEP_BITS'(DVD_BITS);
                    w_dividend      = ept_pkg::TICKS_PER_MINUTE;
                    w_divisor       = r_denom;
                    n_state         = ST_DIV_R;
                end
            end
            ST_DIV_R: begin
                if (w_div_done) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                w_push  = 1'b1;
                n_state = ST_AVG;
            end
            ST_AVG: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state, output valid and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_ppr       <= ept_pkg::PPR_RESET;
            r_max_rpm   <= ept_pkg::MAX_RPM_RESET;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ept_pkg::REG_PPR: begin
                        r_ppr <= i_cfg_data[ept_pkg::PPR_BITS-1:0];
                    end
                    ept_pkg::REG_MAX_RPM: begin
                        r_max_rpm <= i_cfg_data[RPM_BITS-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // working and output words
    always_ff @(posedge i_clk) begin
        if (w_close) begin
            r_period <= w_period;
        end
        if (r_state == ST_MUL) begin
            r_denom <= DIV_BITS'(r_period) * DIV_BITS'(r_ppr);
        end
        if ((r_state == ST_DIV_F) && w_div_done) begin
            r_freq <= w_quo[FREQ_BITS-1:0];
        end
        if ((r_state == ST_DIV_R) && w_div_done) begin
            r_speed <= w_clamped;
        end
        if (r_state == ST_AVG) begin
            r_avg <= w_avg_prod[RCP_SHIFT +: RPM_BITS];
        end
        if (w_load_out) begin
            r_out_freq <= r_freq;
            r_out_raw  <= r_speed;
            r_out_avg  <= r_avg;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_frequency_hz = r_out_freq;
    assign o_raw_rpm      = r_out_raw;
    assign o_average_rpm  = r_out_avg;

endmodule
